@@ hdl/ult_pkg.sv @@
package ult_pkg;

  localparam int DEF_CAPACITY = 32;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 5;
  localparam int ITEM_W       = 6;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_SEARCH = 2'd1;
  localparam logic [1:0] OP_REMOVE = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [1:0]               opcode;
    logic signed [DATA_W-1:0] value;
  } ult_in_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [POS_W-1:0]  position;
    logic [ITEM_W-1:0] item_count;
  } ult_out_t;

  // finished result handed from the sequencer to the output register
  typedef struct packed {
    logic     valid;
    ult_out_t data;
  } ult_res_t;

endpackage

@@ hdl/ult_outreg.sv @@
module ult_outreg (
  input  logic             clk,
  input  logic             rst_n,
  input  ult_pkg::ult_res_t res,
  output logic             res_load,
  output logic             out_valid,
  input  logic             out_stall,
  output ult_pkg::ult_out_t out_data
);
  import ult_pkg::*;

  logic     out_valid_r;
  ult_out_t out_data_r;

  // take a new result whenever the held beat is gone or leaves this cycle
  assign res_load  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid && res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_load) begin
      out_data_r <= res.data;
    end
  end

  a_hold_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> (out_valid_r && $stable(out_data_r)))
    else $error("result beat changed while stalled");

  a_no_load_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !res_load)
    else $error("load offered while held beat is stalled");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (res.valid && res_load) |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

@@ hdl/ult_core.sv @@
module ult_core #(
  parameter int CAPACITY = ult_pkg::DEF_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ult_pkg::ult_in_t  in_data,
  output ult_pkg::ult_res_t res,
  input  logic              res_load
);
  import ult_pkg::*;

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_FETCH,
    S_MOVE,
    S_RESP
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [DATA_W-1:0] val_r, val_nxt;
  logic [CNT_W-1:0]  rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic              rd_pend_r, rd_pend_nxt;
  logic [CNT_W-1:0]  hit_r, hit_nxt;
  ult_out_t          res_r, res_nxt;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data_r;
  logic              mem_we, mem_re;
  logic [IDX_W-1:0]  mem_waddr, mem_raddr;
  logic [DATA_W-1:0] mem_wdata;

  logic [CNT_W-1:0]  last_idx;
  logic              match;

  assign in_stall  = (state_r != S_IDLE);
  assign res.valid = (state_r == S_RESP);
  assign res.data  = res_r;

  assign last_idx = count_r - 1'b1;
  assign match    = rd_pend_r && (rd_data_r == val_r);

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    op_nxt      = op_r;
    val_nxt     = val_r;
    rd_idx_nxt  = rd_idx_r;
    cmp_idx_nxt = cmp_idx_r;
    rd_pend_nxt = rd_pend_r;
    hit_nxt     = hit_r;
    res_nxt     = res_r;
    mem_we      = 1'b0;
    mem_waddr   = count_r[IDX_W-1:0];
    mem_wdata   = in_data.value;
    mem_re      = 1'b0;
    mem_raddr   = rd_idx_r[IDX_W-1:0];

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt      = in_data.opcode;
          val_nxt     = in_data.value;
          rd_idx_nxt  = '0;
          rd_pend_nxt = 1'b0;
          res_nxt.status     = ST_OK;
          res_nxt.position   = '0;
          res_nxt.item_count = ITEM_W'(count_r);
          state_nxt          = S_RESP;
          case (in_data.opcode)
            OP_INSERT: begin
              if (count_r == CAP_CNT) begin
                res_nxt.status = ST_FULL;
              end else begin
                mem_we             = 1'b1;
                count_nxt          = count_r + 1'b1;
                res_nxt.position   = POS_W'(count_r);
                res_nxt.item_count = ITEM_W'(count_nxt);
              end
            end
            OP_SEARCH: begin
              if (count_r == '0) begin
                res_nxt.status = ST_NOTFOUND;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            OP_REMOVE: begin
              if (count_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        // read of entry k is issued while entry k-1 is compared
        if (match) begin
          hit_nxt            = cmp_idx_r;
          res_nxt.status     = ST_OK;
          res_nxt.position   = POS_W'(cmp_idx_r);
          res_nxt.item_count = ITEM_W'(count_r);
          if (op_r == OP_SEARCH) begin
            state_nxt = S_RESP;
          end else if (cmp_idx_r == last_idx) begin
            // last entry removed: nothing to move down
            count_nxt          = last_idx;
            res_nxt.item_count = ITEM_W'(last_idx);
            state_nxt          = S_RESP;
          end else begin
            state_nxt = S_FETCH;
          end
        end else if (rd_pend_r && (cmp_idx_r == last_idx)) begin
          res_nxt.status     = ST_NOTFOUND;
          res_nxt.position   = '0;
          res_nxt.item_count = ITEM_W'(count_r);
          state_nxt          = S_RESP;
        end else if (rd_idx_r < count_r) begin
          mem_re      = 1'b1;
          rd_pend_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r;
          rd_idx_nxt  = rd_idx_r + 1'b1;
        end else begin
          rd_pend_nxt = 1'b0;
        end
      end

      S_FETCH: begin
        mem_re      = 1'b1;
        mem_raddr   = last_idx[IDX_W-1:0];
        rd_pend_nxt = 1'b0;
        state_nxt   = S_MOVE;
      end

      S_MOVE: begin
        mem_we             = 1'b1;
        mem_waddr          = hit_r[IDX_W-1:0];
        mem_wdata          = rd_data_r;
        count_nxt          = last_idx;
        res_nxt.item_count = ITEM_W'(last_idx);
        state_nxt          = S_RESP;
      end

      S_RESP: begin
        if (res_load) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
    op_r      <= op_nxt;
    val_r     <= val_nxt;
    rd_idx_r  <= rd_idx_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hit_r     <= hit_nxt;
    res_r     <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("entry count above capacity");

  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == S_IDLE || state_r == S_MOVE))
    else $error("table written outside insert or move");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && rd_pend_r) |-> (cmp_idx_r < count_r))
    else $error("compare beyond entry count");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted beat did not start work");

  a_move_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MOVE) |=> (count_r == CNT_W'($past(count_r) - 1'b1)))
    else $error("remove did not drop the count");

endmodule

@@ hdl/unordered_list_table.sv @@
// Fixed-capacity unordered list of signed 32-bit values held in one
// single-port-read, single-port-write table with a registered read. One beat
// is worked on at a time: search and remove scan the table one entry per
// cycle through the read port, and a remove that has to move the last entry
// into the hole adds one read and one write back. A finished result waits
// in an output register, so the next beat is taken while that result is
// still stalled. Remove fills the vacated slot with the last entry, so order
// is not kept.
module unordered_list_table #(
  parameter int CAPACITY = ult_pkg::DEF_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ult_pkg::ult_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ult_pkg::ult_out_t out_data
);
  import ult_pkg::*;

  ult_res_t res;
  logic     res_load;

  ult_core #(
    .CAPACITY(CAPACITY)
  ) u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .res      (res),
    .res_load (res_load)
  );

  ult_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .res_load  (res_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

@@ bench/unordered_list_table_tb.sv @@
module unordered_list_table_tb;
  import ult_pkg::*;

  localparam int CAPACITY = DEF_CAPACITY;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_BEATS = 500;

  // one pending beat with its expected result and the pacing that follows it
  typedef struct packed {
    ult_in_t    beat;
    ult_out_t   want;
    logic [7:0] gap;
    logic       drain_first;
  } list_job_t;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  ult_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ult_out_t out_data;

  unordered_list_table #(.CAPACITY(CAPACITY)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  // shadow of the table, advanced as beats are queued
  logic signed [DATA_W-1:0] held_vals [CAPACITY];
  int held_n = 0;

  list_job_t job_backlog [$];
  ult_out_t  due_results [$];

  int beats_sent = 0;
  int results_seen = 0;
  int faults = 0;
  int op_seen [4] = '{0, 0, 0, 0};
  int status_seen [4] = '{0, 0, 0, 0};
  int peak_count = 0;
  logic hold_off = 1'b0;

  function automatic ult_out_t list_outcome(ult_in_t beat);
    ult_out_t res;
    int hit;
    int i;
    res.status = ST_OK;
    res.position = '0;
    hit = -1;
    case (beat.opcode)
      OP_INSERT: begin
        if (held_n >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          held_vals[held_n] = beat.value;
          res.position = POS_W'(held_n);
          held_n++;
        end
      end
      OP_SEARCH, OP_REMOVE: begin
        for (i = 0; i < held_n; i++)
          if (hit < 0 && held_vals[i] == beat.value) hit = i;
        if (beat.opcode == OP_REMOVE && held_n == 0) begin
          res.status = ST_EMPTY;
        end else if (hit < 0) begin
          res.status = ST_NOTFOUND;
        end else begin
          res.position = POS_W'(hit);
          if (beat.opcode == OP_REMOVE) begin
            held_vals[hit] = held_vals[held_n-1];
            held_n--;
          end
        end
      end
      default: ;
    endcase
    res.item_count = ITEM_W'(held_n);
    return res;
  endfunction

  task automatic queue_beat(logic [1:0] op, logic signed [DATA_W-1:0] val, int gap,
                            bit drain_first);
    list_job_t job;
    job.beat.opcode = op;
    job.beat.value = val;
    job.want = list_outcome(job.beat);
    job.gap = 8'(gap);
    job.drain_first = drain_first;
    job_backlog.push_back(job);
    op_seen[op]++;
  endtask

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // mix of held values, a few small values that repeat, and anything at all
  function automatic logic signed [DATA_W-1:0] pick_operand();
    logic signed [DATA_W-1:0] v;
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && held_n > 0) return held_vals[$urandom_range(0, held_n-1)];
    if (r < 70) begin
      v = $urandom_range(0, 7);
      return v - 4;
    end
    v = $urandom;
    return v;
  endfunction

  // sender
  list_job_t nxt;
  ult_out_t  cur_want;
  int        gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      gap_left = 0;
    end else begin
      if (in_valid && !in_stall) begin
        due_results.push_back(cur_want);
        beats_sent++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
          in_valid <= 1'b0;
        end else if (job_backlog.size() != 0 &&
                     !(job_backlog[0].drain_first && due_results.size() != 0)) begin
          nxt = job_backlog.pop_front();
          in_valid <= 1'b1;
          in_data <= nxt.beat;
          cur_want = nxt.want;
          gap_left = nxt.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  ult_out_t got;
  ult_out_t want;
  int stall_left = 0;
  int calm_left = 100;
  bit calm = 1'b0;
  int rs;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = out_data;
        results_seen++;
        status_seen[got.status]++;
        if (got.item_count > peak_count) peak_count = got.item_count;
        if (due_results.size() == 0) begin
          faults++;
          if (faults <= 10)
            $display("unexpected result: status %0d pos %0d count %0d",
                     got.status, got.position, got.item_count);
        end else begin
          want = due_results.pop_front();
          if (got.status !== want.status || got.position !== want.position ||
              got.item_count !== want.item_count) begin
            faults++;
            if (faults <= 10)
              $display("mismatch on result %0d: want %0d/%0d/%0d got %0d/%0d/%0d",
                       results_seen, want.status, want.position, want.item_count,
                       got.status, got.position, got.item_count);
          end
        end
      end
      if (calm_left == 0) begin
        calm = !calm;
        calm_left = $urandom_range(50, 300);
      end else begin
        calm_left--;
      end
      if (stall_left != 0) begin
        stall_left--;
      end else if (!calm) begin
        rs = $urandom_range(0, 99);
        if (rs < 20) stall_left = $urandom_range(1, 3);
        else if (rs < 23) stall_left = $urandom_range(10, 40);
      end
      out_stall <= hold_off || stall_left != 0;
    end
  end

  // long receiver hold-off while the sender keeps offering beats
  initial begin
    while (beats_sent < 200) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2000000;
    $display("timeout: %0d beats sent, %0d results outstanding", beats_sent,
             due_results.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int kind;
    int r;
    int ins_cut;
    int srch_cut;
    int rand_beats;
    bit quiet;
    bit pause;
    logic [1:0] op;

    // empty list, unused opcode, extremes, duplicates, remove of the last slot
    queue_beat(OP_SEARCH, 32'sd0, pick_gap(0), 0);
    queue_beat(OP_REMOVE, 32'sd5, pick_gap(0), 0);
    queue_beat(OP_UNUSED, 32'h5A5A_A5A5, pick_gap(0), 0);
    queue_beat(OP_INSERT, 32'h8000_0000, pick_gap(0), 0);
    queue_beat(OP_INSERT, 32'h7FFF_FFFF, pick_gap(0), 0);
    queue_beat(OP_INSERT, 32'h0000_0000, pick_gap(0), 0);
    queue_beat(OP_INSERT, 32'hFFFF_FFFF, pick_gap(0), 0);
    queue_beat(OP_INSERT, 32'h5555_5555, pick_gap(0), 0);
    queue_beat(OP_INSERT, 32'hAAAA_AAAA, pick_gap(0), 0);
    queue_beat(OP_INSERT, 32'hFFFF_FFFF, pick_gap(0), 0);
    queue_beat(OP_SEARCH, 32'hFFFF_FFFF, pick_gap(0), 0);
    queue_beat(OP_SEARCH, 32'h7FFF_FFFF, pick_gap(0), 0);
    queue_beat(OP_SEARCH, 32'sd12345, pick_gap(0), 0);
    queue_beat(OP_REMOVE, 32'h8000_0000, pick_gap(0), 0);
    queue_beat(OP_SEARCH, 32'hFFFF_FFFF, pick_gap(0), 0);
    queue_beat(OP_REMOVE, 32'hAAAA_AAAA, pick_gap(0), 0);
    queue_beat(OP_REMOVE, 32'sd999, pick_gap(0), 0);
    queue_beat(OP_UNUSED, 32'h0000_0000, pick_gap(0), 0);

    // fill to capacity, push past it, then drain to empty; the sender waits
    // for all results before starting the fill
    pause = 1'b1;
    while (held_n < CAPACITY) begin
      queue_beat(OP_INSERT, pick_operand(), pick_gap(0), pause);
      pause = 1'b0;
    end
    repeat (3) queue_beat(OP_INSERT, $urandom, pick_gap(0), 0);
    queue_beat(OP_SEARCH, held_vals[CAPACITY-1], pick_gap(0), 0);
    while (held_n != 0)
      queue_beat(OP_REMOVE, held_vals[$urandom_range(0, held_n-1)], pick_gap(0), 0);
    queue_beat(OP_REMOVE, $urandom, pick_gap(0), 0);

    // random phases leaning towards filling, draining or a mix
    rand_beats = 0;
    while (rand_beats < RANDOM_BEATS) begin
      kind = $urandom_range(0, 2);
      case (kind)
        0: begin ins_cut = 70; srch_cut = 85; end
        1: begin ins_cut = 12; srch_cut = 30; end
        default: begin ins_cut = 36; srch_cut = 68; end
      endcase
      quiet = ($urandom_range(0, 3) == 0);
      pause = ($urandom_range(0, 4) == 0);
      repeat ($urandom_range(20, 60)) begin
        r = $urandom_range(0, 99);
        if (r < 2) op = OP_UNUSED;
        else if (r < ins_cut) op = OP_INSERT;
        else if (r < srch_cut) op = OP_SEARCH;
        else op = OP_REMOVE;
        queue_beat(op, pick_operand(), pick_gap(quiet), pause);
        pause = 1'b0;
        rand_beats++;
      end
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (job_backlog.size() != 0 || in_valid || due_results.size() != 0)
      @(posedge clk);
    repeat (80) @(posedge clk);

    $display("%0d beats: %0d insert, %0d search, %0d remove, %0d unused opcode",
             beats_sent, op_seen[OP_INSERT], op_seen[OP_SEARCH], op_seen[OP_REMOVE],
             op_seen[OP_UNUSED]);
    $display("results ok/full/empty/not found: %0d/%0d/%0d/%0d, peak fill %0d of %0d",
             status_seen[ST_OK], status_seen[ST_FULL], status_seen[ST_EMPTY],
             status_seen[ST_NOTFOUND], peak_count, CAPACITY);
    if (faults == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", faults);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/ult_pkg.sv
hdl/ult_outreg.sv
hdl/ult_core.sv
hdl/unordered_list_table.sv
bench/unordered_list_table_tb.sv
